// ===== rtl/core/flpu_pkg.sv =====
package flpu_pkg;

   localparam int DATA_W    = 64;
   localparam int FRAC_W    = 32;
   localparam int MAX_TERMS = 64;
   localparam int CNT_W     = 8;
   localparam int STEP_W    = 7;
   localparam int KPROD_W   = 40;

   localparam logic [DATA_W-1:0] ONE_Q   = 64'h0000_0001_0000_0000;
   localparam logic [DATA_W-1:0] LN2_Q   = 64'h0000_0000_B172_17F8;
   localparam logic [DATA_W-1:0] MAX_POS = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [DATA_W-1:0] MIN_NEG = 64'h8000_0000_0000_0000;

   localparam logic [1:0] CMD_LN  = 2'd0;
   localparam logic [1:0] CMD_EXP = 2'd1;
   localparam logic [1:0] CMD_POW = 2'd2;

   localparam logic [1:0] STS_OK     = 2'd0;
   localparam logic [1:0] STS_DOMAIN = 2'd1;
   localparam logic [1:0] STS_OVFL   = 2'd2;
   localparam logic [1:0] STS_UNFL   = 2'd3;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_NORM,
      ST_TDIV_WT,
      ST_SQ_WT,
      ST_LN_CHK,
      ST_LN_DWT,
      ST_LN_MWT,
      ST_LN_KMUL,
      ST_LN_SUM,
      ST_POW_WT,
      ST_EX_GO,
      ST_EX_KWT,
      ST_EX_KMUL,
      ST_EX_R,
      ST_EX_CHK,
      ST_EX_MWT,
      ST_EX_DWT,
      ST_EX_SHIFT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic              start;
      logic [STEP_W-1:0] steps;
   } div_req_type;

endpackage

// ===== rtl/core/fixed_point_log_exp_pow_unit.sv =====
// Fixed-point ln / exp / pow, Q31.32, one item at a time.
// ln: normalise, divide for t, square it, then a divide and a multiply per series
// term; exp: divide by ln2 for k, then a multiply and a divide per term, then shift;
// pow is ln, a multiply by b, then exp. A new item waits for the last to finish: the
// shared bit-serial multiplier and divider carry every step of both series.
// Reset (synchronous, active high) idles the sequencer and drops any result.
module fixed_point_log_exp_pow_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [63:0] req_operand_a,
   input  logic [63:0] req_operand_b,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_value,
   output logic [1:0]  rsp_status
);
   flpu_pkg::state_type state_ff, state_in;

   logic [1:0]  cmd_ff;
   logic [63:0] opb_ff;
   logic [63:0] norm_ff;    // base shifted until its top bit is set
   logic [6:0]  shifts_ff;
   logic signed [6:0] k_ff; // power-of-two scale for ln and exp
   logic [63:0] term_ff;
   logic [63:0] y_ff;       // t squared
   logic [63:0] sum_ff;
   logic [63:0] r_ff;       // exp reduced argument
   logic [63:0] arg_ff;     // exp argument
   logic [flpu_pkg::CNT_W-1:0] cnt_ff;
   logic [flpu_pkg::CNT_W-1:0] d_ff;   // odd divisor of the ln series
   logic signed [flpu_pkg::KPROD_W-1:0] kprod_ff;
   logic [6:0]  sh_ff;
   logic [63:0] res_val_ff;
   logic [1:0]  res_sts_ff;
   logic        rsp_valid_ff;
   logic [63:0] rsp_value_ff;
   logic [1:0]  rsp_status_ff;

   logic        mul_start;
   logic [63:0] mul_a, mul_b;
   logic        mul_done;
   logic [63:0] mul_res;
   flpu_pkg::div_req_type div_req;
   logic [63:0] div_rem, div_dvd, div_den;
   logic        div_done;
   logic [63:0] div_quo;

   logic        accept;
   logic        series_end;
   logic [63:0] ln_v;
   logic [63:0] arg_mag;
   logic [6:0]  kmag;
   logic        out_free;

   flpu_mulq u_mulq (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .op_a   (mul_a),
      .op_b   (mul_b),
      .done   (mul_done),
      .result (mul_res)
   );

   flpu_div u_div (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req),
      .rem_init (div_rem),
      .dividend (div_dvd),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign req_stall  = (state_ff != flpu_pkg::ST_IDLE);
   assign accept     = req_valid && !req_stall;
   assign series_end = (term_ff == 64'd0) || (cnt_ff > flpu_pkg::CNT_W'(flpu_pkg::MAX_TERMS));
   assign ln_v       = {sum_ff[62:0], 1'b0} + 64'(kprod_ff);
   assign arg_mag    = arg_ff[63] ? 64'd0 - arg_ff : arg_ff;
   assign kmag       = k_ff[6] ? 7'(-k_ff) : 7'(k_ff);
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         flpu_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_command == flpu_pkg::CMD_EXP) begin
                  state_in = flpu_pkg::ST_EX_GO;
               end else if ((req_command == flpu_pkg::CMD_LN ||
                             req_command == flpu_pkg::CMD_POW) &&
                            !req_operand_a[63] && req_operand_a != 64'd0) begin
                  state_in = flpu_pkg::ST_NORM;
               end else begin
                  state_in = flpu_pkg::ST_DONE;
               end
            end
         end
         flpu_pkg::ST_NORM:    if (norm_ff[63]) state_in = flpu_pkg::ST_TDIV_WT;
         flpu_pkg::ST_TDIV_WT: if (div_done) state_in = flpu_pkg::ST_SQ_WT;
         flpu_pkg::ST_SQ_WT:   if (mul_done) state_in = flpu_pkg::ST_LN_CHK;
         flpu_pkg::ST_LN_CHK: begin
            state_in = series_end ? flpu_pkg::ST_LN_KMUL : flpu_pkg::ST_LN_DWT;
         end
         flpu_pkg::ST_LN_DWT:  if (div_done) state_in = flpu_pkg::ST_LN_MWT;
         flpu_pkg::ST_LN_MWT:  if (mul_done) state_in = flpu_pkg::ST_LN_CHK;
         flpu_pkg::ST_LN_KMUL: state_in = flpu_pkg::ST_LN_SUM;
         flpu_pkg::ST_LN_SUM: begin
            state_in = (cmd_ff == flpu_pkg::CMD_POW) ? flpu_pkg::ST_POW_WT
                                                     : flpu_pkg::ST_DONE;
         end
         flpu_pkg::ST_POW_WT:  if (mul_done) state_in = flpu_pkg::ST_EX_GO;
         flpu_pkg::ST_EX_GO:   state_in = flpu_pkg::ST_EX_KWT;
         flpu_pkg::ST_EX_KWT: begin
            if (div_done) begin
               if ((!arg_ff[63] && div_quo >= 64'd63) ||
                   (arg_ff[63] && div_quo > 64'd33)) begin
                  state_in = flpu_pkg::ST_DONE;
               end else begin
                  state_in = flpu_pkg::ST_EX_KMUL;
               end
            end
         end
         flpu_pkg::ST_EX_KMUL: state_in = flpu_pkg::ST_EX_R;
         flpu_pkg::ST_EX_R:    state_in = flpu_pkg::ST_EX_CHK;
         flpu_pkg::ST_EX_CHK: begin
            state_in = series_end ? flpu_pkg::ST_EX_SHIFT : flpu_pkg::ST_EX_MWT;
         end
         flpu_pkg::ST_EX_MWT:  if (mul_done) state_in = flpu_pkg::ST_EX_DWT;
         flpu_pkg::ST_EX_DWT:  if (div_done) state_in = flpu_pkg::ST_EX_CHK;
         flpu_pkg::ST_EX_SHIFT: begin
            if (sh_ff == kmag) begin
               state_in = flpu_pkg::ST_DONE;
            end else if (!k_ff[6] && (sum_ff[63] || sum_ff[62])) begin
               state_in = flpu_pkg::ST_DONE;
            end
         end
         flpu_pkg::ST_DONE:    if (out_free) state_in = flpu_pkg::ST_IDLE;
         default:              state_in = flpu_pkg::ST_IDLE;
      endcase
   end

   // Unit requests
   always_comb begin
      mul_start     = 1'b0;
      mul_a         = term_ff;
      mul_b         = y_ff;
      div_req.start = 1'b0;
      div_req.steps = 7'd64;
      div_rem       = 64'd0;
      div_dvd       = term_ff;
      div_den       = 64'(d_ff);
      unique case (state_ff)
         flpu_pkg::ST_NORM: begin
            // t = (x-1)/(x+1) with x = norm[63:31], a fraction of 32 bits
            if (norm_ff[63]) begin
               div_req.start = 1'b1;
               div_req.steps = 7'(flpu_pkg::FRAC_W);
               div_rem       = {32'd0, norm_ff[62:31]};
               div_dvd       = 64'd0;
               div_den       = {30'd0, 2'b10, norm_ff[62:31]};
            end
         end
         flpu_pkg::ST_TDIV_WT: begin
            if (div_done) begin
               mul_start = 1'b1;
               mul_a     = div_quo;
               mul_b     = div_quo;
            end
         end
         flpu_pkg::ST_LN_CHK: begin
            if (!series_end) div_req.start = 1'b1;
         end
         flpu_pkg::ST_LN_DWT: begin
            if (div_done) mul_start = 1'b1;
         end
         flpu_pkg::ST_LN_SUM: begin
            if (cmd_ff == flpu_pkg::CMD_POW) begin
               mul_start = 1'b1;
               mul_a     = ln_v;
               mul_b     = opb_ff;
            end
         end
         flpu_pkg::ST_EX_GO: begin
            div_req.start = 1'b1;
            div_dvd       = arg_mag;
            div_den       = flpu_pkg::LN2_Q;
         end
         flpu_pkg::ST_EX_CHK: begin
            if (!series_end) begin
               mul_start = 1'b1;
               mul_b     = r_ff;
            end
         end
         flpu_pkg::ST_EX_MWT: begin
            if (mul_done) begin
               div_req.start = 1'b1;
               div_dvd       = mul_res;
               div_den       = 64'(cnt_ff + 1'b1);
            end
         end
         default: ;
      endcase
   end

   // Datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= flpu_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         // raise valid on a new result, drop it once the transfer is done
         if (state_ff == flpu_pkg::ST_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            flpu_pkg::ST_IDLE: begin
               if (accept) begin
                  cmd_ff     <= req_command;
                  opb_ff     <= req_operand_b;
                  arg_ff     <= req_operand_a;
                  norm_ff    <= req_operand_a;
                  shifts_ff  <= 7'd0;
                  res_val_ff <= 64'd0;
                  res_sts_ff <= flpu_pkg::STS_DOMAIN;
               end
            end
            flpu_pkg::ST_NORM: begin
               if (norm_ff[63]) begin
                  k_ff <= 7'sd31 - $signed(shifts_ff);
               end else begin
                  norm_ff   <= {norm_ff[62:0], 1'b0};
                  shifts_ff <= shifts_ff + 7'd1;
               end
            end
            flpu_pkg::ST_TDIV_WT: if (div_done) term_ff <= div_quo;
            flpu_pkg::ST_SQ_WT: begin
               if (mul_done) begin
                  y_ff   <= mul_res;
                  sum_ff <= 64'd0;
                  cnt_ff <= flpu_pkg::CNT_W'(1);
                  d_ff   <= flpu_pkg::CNT_W'(1);
               end
            end
            flpu_pkg::ST_LN_DWT: if (div_done) sum_ff <= sum_ff + div_quo;
            flpu_pkg::ST_LN_MWT: begin
               if (mul_done) begin
                  term_ff <= mul_res;
                  cnt_ff  <= cnt_ff + 1'b1;
                  d_ff    <= d_ff + flpu_pkg::CNT_W'(2);
               end
            end
            flpu_pkg::ST_LN_KMUL, flpu_pkg::ST_EX_KMUL: begin
               // widen both factors first so k * ln2 keeps all its bits
               kprod_ff <= flpu_pkg::KPROD_W'(k_ff) *
                           flpu_pkg::KPROD_W'($signed({1'b0, flpu_pkg::LN2_Q[31:0]}));
            end
            flpu_pkg::ST_LN_SUM: begin
               res_val_ff <= ln_v;
               res_sts_ff <= flpu_pkg::STS_OK;
            end
            flpu_pkg::ST_POW_WT: if (mul_done) arg_ff <= mul_res;
            flpu_pkg::ST_EX_KWT: begin
               if (div_done) begin
                  // k = -q-1 below zero, q otherwise
                  k_ff <= arg_ff[63] ? $signed(~div_quo[6:0]) : $signed(div_quo[6:0]);
                  if (!arg_ff[63]) begin
                     res_val_ff <= flpu_pkg::MAX_POS;
                     res_sts_ff <= flpu_pkg::STS_OVFL;
                  end else begin
                     res_val_ff <= 64'd0;
                     res_sts_ff <= flpu_pkg::STS_UNFL;
                  end
               end
            end
            flpu_pkg::ST_EX_R: begin
               r_ff    <= arg_ff - 64'(kprod_ff);
               term_ff <= arg_ff - 64'(kprod_ff);
               sum_ff  <= flpu_pkg::ONE_Q;
               cnt_ff  <= flpu_pkg::CNT_W'(1);
            end
            flpu_pkg::ST_EX_CHK: begin
               sh_ff <= 7'd0;
               if (!series_end) sum_ff <= sum_ff + term_ff;
            end
            flpu_pkg::ST_EX_DWT: begin
               if (div_done) begin
                  term_ff <= div_quo;
                  cnt_ff  <= cnt_ff + 1'b1;
               end
            end
            flpu_pkg::ST_EX_SHIFT: begin
               if (sh_ff == kmag) begin
                  res_val_ff <= sum_ff;
                  res_sts_ff <= (sum_ff == 64'd0) ? flpu_pkg::STS_UNFL : flpu_pkg::STS_OK;
               end else if (!k_ff[6] && (sum_ff[63] || sum_ff[62])) begin
                  res_val_ff <= flpu_pkg::MAX_POS;
                  res_sts_ff <= flpu_pkg::STS_OVFL;
               end else begin
                  // advance one bit toward the final scale
                  sum_ff <= k_ff[6] ? {1'b0, sum_ff[63:1]} : {sum_ff[62:0], 1'b0};
                  sh_ff  <= sh_ff + 7'd1;
               end
            end
            flpu_pkg::ST_DONE: begin
               if (out_free) begin
                  rsp_value_ff  <= res_val_ff;
                  rsp_status_ff <= res_sts_ff;
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

   a_one_unit_start: assert property (@(posedge clock) disable iff (reset)
      !(mul_start && div_req.start))
      else $error("multiplier and divider started together");

   a_k_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == flpu_pkg::ST_EX_SHIFT) |-> (k_ff >= -7'sd34 && k_ff <= 7'sd62))
      else $error("exp scale out of range");

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid_ff)
      else $error("result valid after reset");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && $stable(rsp_value_ff)))
      else $error("pending result lost");
endmodule

// ===== rtl/core/flpu_mulq.sv =====
// Bit-serial signed fixed-point multiply: truncate toward zero, saturate.
module flpu_mulq (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] op_a,
   input  logic [63:0] op_b,
   output logic        done,
   output logic [63:0] result
);
   logic [63:0] mcand_ff;
   logic [63:0] mpl_ff;
   logic [63:0] acc_ff;
   logic [5:0]  cnt_ff;
   logic        busy_ff;
   logic        fin_ff;
   logic        done_ff;
   logic        neg_ff;
   logic [63:0] res_ff;
   logic [64:0] sum;
   logic [63:0] rlo;
   logic [31:0] rhi;
   logic [63:0] lim;
   logic        sat;

   assign sum = {1'b0, acc_ff} + (mpl_ff[0] ? {1'b0, mcand_ff} : 65'd0);
   assign rlo = {acc_ff[31:0], mpl_ff[63:32]};
   assign rhi = acc_ff[63:32];
   assign lim = neg_ff ? flpu_pkg::MIN_NEG : flpu_pkg::MAX_POS;
   assign sat = (rhi != 32'd0) || (rlo > lim);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            mcand_ff <= op_a[63] ? 64'd0 - op_a : op_a;
            mpl_ff   <= op_b[63] ? 64'd0 - op_b : op_b;
            acc_ff   <= 64'd0;
            cnt_ff   <= 6'd0;
            neg_ff   <= op_a[63] ^ op_b[63];
            busy_ff  <= 1'b1;
         end else if (busy_ff) begin
            // shift one multiplier bit out, one product bit in
            acc_ff <= sum[64:1];
            mpl_ff <= {sum[0], mpl_ff[63:1]};
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               busy_ff <= 1'b0;
               fin_ff  <= 1'b1;
            end
         end else if (fin_ff) begin
            fin_ff  <= 1'b0;
            done_ff <= 1'b1;
            if (sat) begin
               res_ff <= neg_ff ? flpu_pkg::MIN_NEG : flpu_pkg::MAX_POS;
            end else begin
               res_ff <= neg_ff ? 64'd0 - rlo : rlo;
            end
         end
      end
   end

   assign done   = done_ff;
   assign result = res_ff;
endmodule

// ===== rtl/core/flpu_div.sv =====
// Restoring divider, one quotient bit per cycle.
module flpu_div (
   input  logic                 clock,
   input  logic                 reset,
   input  flpu_pkg::div_req_type req,
   input  logic [63:0]          rem_init,
   input  logic [63:0]          dividend,
   input  logic [63:0]          divisor,
   output logic                 done,
   output logic [63:0]          quotient
);
   logic [63:0] rem_ff;
   logic [63:0] quo_ff;
   logic [63:0] den_ff;
   logic [flpu_pkg::STEP_W-1:0] cnt_ff;
   logic [flpu_pkg::STEP_W-1:0] steps_ff;
   logic        busy_ff;
   logic        done_ff;
   logic [64:0] sh;
   logic        fit;

   assign sh  = {rem_ff, quo_ff[63]};
   assign fit = sh >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            rem_ff   <= rem_init;
            quo_ff   <= dividend;
            den_ff   <= divisor;
            steps_ff <= req.steps;
            cnt_ff   <= '0;
            busy_ff  <= 1'b1;
         end else if (busy_ff) begin
            rem_ff <= fit ? 64'(sh - {1'b0, den_ff}) : sh[63:0];
            quo_ff <= {quo_ff[62:0], fit};
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff + 1'b1 == steps_ff) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

// ===== tb/fixed_point_log_exp_pow_unit_tb.sv =====
module fixed_point_log_exp_pow_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // one result item: value and status, as the block returns them
   typedef struct packed {
      logic [63:0] value;
      logic [1:0]  status;
   } outcome_type;

   // one row of the directed table; typed rows carry their own expectation
   typedef struct packed {
      logic [1:0]  cmd;
      logic [63:0] a;
      logic [63:0] b;
      logic        typed;
      logic [63:0] value;
      logic [1:0]  status;
   } stim_row_type;

   localparam int N_DIRECTED = 22;
   localparam int N_RANDOM   = 300;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_command = flpu_pkg::CMD_LN;
   logic [63:0] req_operand_a = '0;
   logic [63:0] req_operand_b = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_value;
   logic [1:0]  rsp_status;

   // idle rates in percent, switched by the stimulus process per phase
   int unsigned send_idle_pct = 22;
   int unsigned recv_idle_pct = 71;

   outcome_type pending_results[$];
   int unsigned mismatch_count = 0;

   fixed_point_log_exp_pow_unit dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_command   (req_command),
      .req_operand_a (req_operand_a),
      .req_operand_b (req_operand_b),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_value     (rsp_value),
      .rsp_status    (rsp_status)
   );

   // 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Predictor: Q31.32 arithmetic rebuilt at the block's widths
   // ---------------------------------------------------------------------

   // ln2 rounded to nearest at 32 fraction bits
   function automatic longint ln2_fixed();
      logic [63:0] ln2_q62;
      ln2_q62 = 64'h2C5C_85FD_F473_DE6B;
      return longint'((ln2_q62 + (64'd1 << 29)) >> 30);
   endfunction

   // signed product, truncated toward zero, saturated to 64 bits
   function automatic logic [63:0] q_mul(input logic [63:0] a, input logic [63:0] b);
      logic         neg;
      logic [63:0]  ua, ub;
      logic [127:0] prod, mag, lim;
      neg  = a[63] ^ b[63];
      ua   = a[63] ? -a : a;
      ub   = b[63] ? -b : b;
      prod = {64'd0, ua} * {64'd0, ub};
      mag  = prod >> 32;
      lim  = neg ? {64'd0, flpu_pkg::MIN_NEG} : {64'd0, flpu_pkg::MAX_POS};
      if (mag > lim) return neg ? flpu_pkg::MIN_NEG : flpu_pkg::MAX_POS;
      return neg ? -mag[63:0] : mag[63:0];
   endfunction

   // floor(num * 2^32 / den), num below den
   function automatic logic [63:0] frac_quotient(input logic [63:0] num,
                                                 input logic [63:0] den);
      logic [63:0] rem, q;
      rem = num;
      q   = '0;
      for (int i = 0; i < 32; i++) begin
         rem = rem << 1;
         q   = q << 1;
         if (rem >= den) begin
            rem  = rem - den;
            q[0] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic outcome_type natural_log(input logic [63:0] a);
      outcome_type res;
      logic [63:0] x, t, y, term, sum;
      int          p;
      longint      k;
      res = '0;
      if ($signed(a) <= 0) begin
         res.status = flpu_pkg::STS_DOMAIN;
         return res;
      end
      p = 63;
      while (p > 0 && !a[p]) p--;
      k = p - 32;
      x = (k > 0) ? (a >> k) : (a << (-k));
      t = frac_quotient(x - flpu_pkg::ONE_Q, x + flpu_pkg::ONE_Q);
      y = q_mul(t, t);
      term = t;
      sum  = '0;
      for (int i = 1; i <= flpu_pkg::MAX_TERMS; i++) begin
         if (term == 0) break;
         sum  = sum + term / 64'(2 * i - 1);
         term = q_mul(term, y);
      end
      res.value  = 64'(longint'(sum) * 2 + k * ln2_fixed());
      res.status = flpu_pkg::STS_OK;
      return res;
   endfunction

   function automatic outcome_type exponential(input logic [63:0] a_raw);
      outcome_type res;
      longint      a, l2, k, r;
      logic [63:0] sum, term, prod, shifted;
      a   = longint'(a_raw);
      l2  = ln2_fixed();
      k   = a / l2 - ((a < 0) ? 1 : 0);
      res = '0;
      if (k >= 63) begin
         res.value  = flpu_pkg::MAX_POS;
         res.status = flpu_pkg::STS_OVFL;
         return res;
      end
      if (k < -34) begin
         res.status = flpu_pkg::STS_UNFL;
         return res;
      end
      r    = a - k * l2;
      term = 64'(r);
      sum  = flpu_pkg::ONE_Q;
      for (int n = 1; n <= flpu_pkg::MAX_TERMS; n++) begin
         if (term == 0) break;
         sum  = sum + term;
         prod = q_mul(term, 64'(r));
         term = prod / 64'(n + 1);
      end
      if (k >= 0) begin
         if (sum > (flpu_pkg::MAX_POS >> k)) begin
            res.value  = flpu_pkg::MAX_POS;
            res.status = flpu_pkg::STS_OVFL;
         end else begin
            res.value  = sum << k;
            res.status = flpu_pkg::STS_OK;
         end
         return res;
      end
      shifted    = sum >> (-k);
      res.value  = shifted;
      res.status = (shifted == 0) ? flpu_pkg::STS_UNFL : flpu_pkg::STS_OK;
      return res;
   endfunction

   function automatic outcome_type predict_outcome(input logic [1:0] cmd,
                                                   input logic [63:0] a,
                                                   input logic [63:0] b);
      outcome_type res, lg;
      res = '0;
      case (cmd)
         flpu_pkg::CMD_LN:  res = natural_log(a);
         flpu_pkg::CMD_EXP: res = exponential(a);
         flpu_pkg::CMD_POW: begin
            lg = natural_log(a);
            if (lg.status == flpu_pkg::STS_DOMAIN) res.status = flpu_pkg::STS_DOMAIN;
            else res = exponential(q_mul(lg.value, b));
         end
         default: res.status = flpu_pkg::STS_DOMAIN;
      endcase
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------

   function automatic logic [63:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   // Present one item and hold it until the transfer; idle first at the
   // sender's current rate. Called just after a rising edge.
   task automatic send_item(input logic [1:0] cmd, input logic [63:0] a,
                            input logic [63:0] b, input outcome_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_command   <= cmd;
      req_operand_a <= a;
      req_operand_b <= b;
      do @(posedge clock); while (req_stall);
      pending_results = {pending_results, want};
   endtask

   stim_row_type directed_rows [N_DIRECTED] = '{
      // domain errors: zero, negative and most negative base
      '{flpu_pkg::CMD_LN, 64'd0, 64'd0, 1'b1, 64'd0, flpu_pkg::STS_DOMAIN},
      '{flpu_pkg::CMD_LN, flpu_pkg::MIN_NEG, flpu_pkg::MAX_POS,
        1'b1, 64'd0, flpu_pkg::STS_DOMAIN},
      '{flpu_pkg::CMD_LN, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0,
        1'b1, 64'd0, flpu_pkg::STS_DOMAIN},
      '{flpu_pkg::CMD_POW, 64'd0, flpu_pkg::ONE_Q, 1'b1, 64'd0, flpu_pkg::STS_DOMAIN},
      '{flpu_pkg::CMD_POW, flpu_pkg::MIN_NEG, flpu_pkg::MIN_NEG,
        1'b1, 64'd0, flpu_pkg::STS_DOMAIN},
      // unused command
      '{2'd3, flpu_pkg::MAX_POS, flpu_pkg::MAX_POS, 1'b1, 64'd0, flpu_pkg::STS_DOMAIN},
      '{2'd3, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
        1'b1, 64'd0, flpu_pkg::STS_DOMAIN},
      // exact points: ln 1 and exp 0
      '{flpu_pkg::CMD_LN, flpu_pkg::ONE_Q, flpu_pkg::MIN_NEG,
        1'b1, 64'd0, flpu_pkg::STS_OK},
      '{flpu_pkg::CMD_EXP, 64'd0, 64'd0, 1'b1, flpu_pkg::ONE_Q, flpu_pkg::STS_OK},
      // exp saturates high and truncates to zero at the extremes
      '{flpu_pkg::CMD_EXP, flpu_pkg::MAX_POS, 64'd0,
        1'b1, flpu_pkg::MAX_POS, flpu_pkg::STS_OVFL},
      '{flpu_pkg::CMD_EXP, flpu_pkg::MIN_NEG, 64'd0, 1'b1, 64'd0, flpu_pkg::STS_UNFL},
      // the rest against the predictor
      '{flpu_pkg::CMD_LN, flpu_pkg::MAX_POS, 64'd0, 1'b0, 64'd0, flpu_pkg::STS_OK},
      '{flpu_pkg::CMD_LN, 64'd1, 64'd0, 1'b0, 64'd0, flpu_pkg::STS_OK},
      '{flpu_pkg::CMD_LN, 64'h0000_0002_0000_0000, 64'd0,
        1'b0, 64'd0, flpu_pkg::STS_OK},
      '{flpu_pkg::CMD_EXP, flpu_pkg::ONE_Q, 64'd0, 1'b0, 64'd0, flpu_pkg::STS_OK},
      '{flpu_pkg::CMD_EXP, 64'hFFFF_FFFF_0000_0000, 64'd0,
        1'b0, 64'd0, flpu_pkg::STS_OK},
      '{flpu_pkg::CMD_EXP, 64'h0000_0029_0000_0000, 64'd0,
        1'b0, 64'd0, flpu_pkg::STS_OK},
      '{flpu_pkg::CMD_EXP, 64'hFFFF_FFE8_0000_0000, 64'd0,
        1'b0, 64'd0, flpu_pkg::STS_OK},
      '{flpu_pkg::CMD_POW, 64'h0000_0002_0000_0000, 64'h0000_0000_8000_0000,
        1'b0, 64'd0, flpu_pkg::STS_OK},
      '{flpu_pkg::CMD_POW, flpu_pkg::ONE_Q, flpu_pkg::MAX_POS,
        1'b0, 64'd0, flpu_pkg::STS_OK},
      '{flpu_pkg::CMD_POW, flpu_pkg::MAX_POS, flpu_pkg::MAX_POS,
        1'b0, 64'd0, flpu_pkg::STS_OK},
      '{flpu_pkg::CMD_POW, flpu_pkg::MAX_POS, flpu_pkg::MIN_NEG,
        1'b0, 64'd0, flpu_pkg::STS_OK}
   };

   initial begin
      outcome_type want;
      logic [1:0]  cmd;
      logic [63:0] a, b;
      int unsigned pick;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table; typed rows use their own expectation
      foreach (directed_rows[i]) begin
         if (directed_rows[i].typed) begin
            want.value  = directed_rows[i].value;
            want.status = directed_rows[i].status;
         end else begin
            want = predict_outcome(directed_rows[i].cmd, directed_rows[i].a,
                                   directed_rows[i].b);
         end
         send_item(directed_rows[i].cmd, directed_rows[i].a, directed_rows[i].b, want);
      end

      for (int n = 0; n < N_RANDOM; n++) begin
         // swap idle rates by thirds, then run with no idling at all
         if (n == N_RANDOM / 3) begin
            send_idle_pct = 71;
            recv_idle_pct = 22;
         end else if (n == 2 * N_RANDOM / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         pick = $urandom_range(99);
         b    = rand_word();
         if (pick < 10) begin
            // noise: any command, any bits
            cmd = 2'($urandom_range(3));
            a   = rand_word();
         end else if (pick < 40) begin
            // ln over every magnitude of a positive argument
            cmd = flpu_pkg::CMD_LN;
            a   = rand_word() >> $urandom_range(1, 63);
            if (a == 0) a = 64'd1;
         end else if (pick < 70) begin
            // exp mostly inside the representable range
            cmd = flpu_pkg::CMD_EXP;
            a   = {26'd0, 6'($urandom_range(0, 47)), 32'($urandom)};
            if ($urandom_range(1)) a = -a;
         end else begin
            // pow with a moderate base and exponent
            cmd = flpu_pkg::CMD_POW;
            a   = rand_word() >> $urandom_range(20, 40);
            if (a == 0) a = flpu_pkg::ONE_Q;
            b   = {29'd0, 3'($urandom_range(0, 7)), 32'($urandom)};
            if ($urandom_range(1)) b = -b;
         end
         send_item(cmd, a, b, predict_outcome(cmd, a, b));
      end
      req_valid <= 1'b0;

      // drain, then let the block settle
      while (pending_results.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);

      if (mismatch_count == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Result side: random stall, check each transfer against the oldest
   // expectation
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result value=%h status=%0d", rsp_value, rsp_status);
         end else begin
            want = pending_results.pop_front();
            if (rsp_value !== want.value || rsp_status !== want.status) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected value=%h status=%0d, got value=%h status=%0d",
                           want.value, want.status, rsp_value, rsp_status);
            end
         end
      end
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // hard stop well past the slowest legal run
   initial begin
      #100ms;
      $display("Verification failed");
      $finish;
   end

endmodule
